>>> hdl/tlhh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhh_pkg
// Shared types, codes and helpers for the three-level health hysteresis block.
// ----------------------------------------------------------------------------
package tlhh_pkg;

  // Field widths fixed by the data formats.
  localparam int TIME_W  = 32;
  localparam int SCORE_W = 16;
  localparam int CONF_W  = 16;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Default debounce lengths and initial status.
  localparam int DEF_HEALTHY_EXIT_TICKS  = 3;
  localparam int DEF_HEALTHY_ENTER_TICKS = 3;
  localparam int DEF_DOWN_ENTER_TICKS    = 3;
  localparam int DEF_DOWN_EXIT_TICKS     = 3;
  localparam int DEF_INITIAL_STATUS      = 0;

  // Health status levels.
  typedef enum logic [1:0] {
    ST_HEALTHY  = 2'd0,
    ST_DEGRADED = 2'd1,
    ST_DOWN     = 2'd2
  } status_t;

  // Transition reason codes.
  typedef enum logic [2:0] {
    RSN_NONE          = 3'd0,
    RSN_FORCED        = 3'd1,
    RSN_HEALTHY_EXIT  = 3'd2,
    RSN_DOWN_ENTER    = 3'd3,
    RSN_HEALTHY_ENTER = 3'd4,
    RSN_DOWN_EXIT     = 3'd5
  } reason_t;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_HEALTHY_EXIT_LEVEL  = 3'd0,
    CFG_HEALTHY_ENTER_LEVEL = 3'd1,
    CFG_DOWN_ENTER_LEVEL    = 3'd2,
    CFG_DOWN_EXIT_LEVEL     = 3'd3,
    CFG_MIN_DWELL_TIME      = 3'd4,
    CFG_PROMOTION_CONF      = 3'd5,
    CFG_FORCE_DOWN_CONF     = 3'd6,
    CFG_FORCE_DOWN_ENABLE   = 3'd7
  } cfg_idx_t;

  // Saturating increment of a run-length counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    return (&cnt) ? cnt : cnt + CNT_W'(1);
  endfunction

endpackage

>>> hdl/three_level_health_hysteresis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_health_hysteresis
// Healthy / degraded / down status tracker with debounce counters and dwell.
// ----------------------------------------------------------------------------
// One result transaction leaves for every input transaction, in order. An
// item is captured in an input register, evaluated combinationally against
// the status and counters, and lands in the output register, which drives
// out_tvalid. One item is accepted every cycle while the output side keeps
// up. The status feedback loop (compare, counter bump, dwell subtract and
// compare) closes combinationally, from the state registers back to them.
// Configuration writes must be made while no transaction is in flight.
// ----------------------------------------------------------------------------
module three_level_health_hysteresis
  import tlhh_pkg::*;
#(
  parameter int HEALTHY_EXIT_TICKS  = DEF_HEALTHY_EXIT_TICKS,
  parameter int HEALTHY_ENTER_TICKS = DEF_HEALTHY_ENTER_TICKS,
  parameter int DOWN_ENTER_TICKS    = DEF_DOWN_ENTER_TICKS,
  parameter int DOWN_EXIT_TICKS     = DEF_DOWN_EXIT_TICKS,
  parameter int INITIAL_STATUS      = DEF_INITIAL_STATUS
) (
  input  logic             clk,
  input  logic             rst_n,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // Input stream: [31:0] tick_time, [47:32] score_value, [63:48] confidence_value.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,
  // Result stream: [1:0] status_now, [2] changed_flag, [5:3] reason_code, [7:6] zero.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata
);

  localparam logic [CNT_W-1:0] HX_TICKS = CNT_W'(HEALTHY_EXIT_TICKS);
  localparam logic [CNT_W-1:0] HE_TICKS = CNT_W'(HEALTHY_ENTER_TICKS);
  localparam logic [CNT_W-1:0] DE_TICKS = CNT_W'(DOWN_ENTER_TICKS);
  localparam logic [CNT_W-1:0] DX_TICKS = CNT_W'(DOWN_EXIT_TICKS);
  localparam logic [1:0] INIT_CODE =
    (INITIAL_STATUS > 2) ? 2'(ST_DOWN) : 2'(INITIAL_STATUS);

  // Configuration registers.
  logic signed [SCORE_W-1:0] healthy_exit_level_r;
  logic signed [SCORE_W-1:0] healthy_enter_level_r;
  logic signed [SCORE_W-1:0] down_enter_level_r;
  logic signed [SCORE_W-1:0] down_exit_level_r;
  logic [CFG_W-1:0]          min_dwell_time_r;
  logic [CONF_W-1:0]         promotion_conf_r;
  logic [CONF_W-1:0]         force_down_conf_r;
  logic                      force_down_enable_r;

  // Input stage.
  logic                      s1_valid_r;
  logic [TIME_W-1:0]         s1_time_r;
  logic signed [SCORE_W-1:0] s1_score_r;
  logic [CONF_W-1:0]         s1_conf_r;
  logic                      s1_adv;

  // Status state.
  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  hx_cnt_r, hx_cnt_nxt;
  logic [CNT_W-1:0]  he_cnt_r, he_cnt_nxt;
  logic [CNT_W-1:0]  de_cnt_r, de_cnt_nxt;
  logic [CNT_W-1:0]  dx_cnt_r, dx_cnt_nxt;
  logic [TIME_W-1:0] last_change_r;
  logic              has_changed_r;
  logic              changed_nxt;
  reason_t           reason_nxt;

  // Output register.
  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_changed_r;
  reason_t           out_reason_r;

  // Combinational helpers.
  logic [TIME_W-1:0] elapsed;
  logic              dwell_ok;
  logic              force_down;
  logic              allow_promo;
  logic [CNT_W-1:0]  hx_bump, he_bump, de_bump, dx_bump;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      healthy_exit_level_r  <= '0;
      healthy_enter_level_r <= '0;
      down_enter_level_r    <= '0;
      down_exit_level_r     <= '0;
      min_dwell_time_r      <= '0;
      promotion_conf_r      <= '0;
      force_down_conf_r     <= '0;
      force_down_enable_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEALTHY_EXIT_LEVEL:  healthy_exit_level_r  <= cfg_wdata;
        CFG_HEALTHY_ENTER_LEVEL: healthy_enter_level_r <= cfg_wdata;
        CFG_DOWN_ENTER_LEVEL:    down_enter_level_r    <= cfg_wdata;
        CFG_DOWN_EXIT_LEVEL:     down_exit_level_r     <= cfg_wdata;
        CFG_MIN_DWELL_TIME:      min_dwell_time_r      <= cfg_wdata;
        CFG_PROMOTION_CONF:      promotion_conf_r      <= cfg_wdata;
        CFG_FORCE_DOWN_CONF:     force_down_conf_r     <= cfg_wdata;
        CFG_FORCE_DOWN_ENABLE:   force_down_enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on when the output register is free or drains.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_time_r  <= in_tdata[31:0];
      s1_score_r <= in_tdata[47:32];
      s1_conf_r  <= in_tdata[63:48];
    end
  end

  // Shared per-tick conditions.
  assign elapsed     = s1_time_r - last_change_r;
  assign dwell_ok    = (min_dwell_time_r == '0) || !has_changed_r ||
                       (elapsed >= {{(TIME_W-CFG_W){1'b0}}, min_dwell_time_r});
  assign force_down  = force_down_enable_r && (s1_conf_r < force_down_conf_r) &&
                       (status_r != ST_DOWN);
  assign allow_promo = s1_conf_r >= promotion_conf_r;
  assign hx_bump     = (s1_score_r <= healthy_exit_level_r) ? sat_inc(hx_cnt_r) : '0;
  assign de_bump     = (s1_score_r <= down_enter_level_r) ? sat_inc(de_cnt_r) : '0;
  assign he_bump     = (allow_promo && s1_score_r >= healthy_enter_level_r) ?
                       sat_inc(he_cnt_r) : '0;
  assign dx_bump     = (s1_score_r >= down_exit_level_r) ? sat_inc(dx_cnt_r) : '0;

  // Next status, counters and reason for the item in the input stage.
  always_comb begin
    status_nxt  = status_r;
    hx_cnt_nxt  = hx_cnt_r;
    he_cnt_nxt  = he_cnt_r;
    de_cnt_nxt  = de_cnt_r;
    dx_cnt_nxt  = dx_cnt_r;
    changed_nxt = 1'b0;
    reason_nxt  = RSN_NONE;
    if (force_down) begin
      status_nxt  = ST_DOWN;
      changed_nxt = 1'b1;
      reason_nxt  = RSN_FORCED;
    end else begin
      unique case (status_r)
        ST_HEALTHY: begin
          hx_cnt_nxt = hx_bump;
          if (hx_bump >= HX_TICKS && dwell_ok) begin
            status_nxt  = ST_DEGRADED;
            changed_nxt = 1'b1;
            reason_nxt  = RSN_HEALTHY_EXIT;
          end
        end
        ST_DEGRADED: begin
          de_cnt_nxt = de_bump;
          he_cnt_nxt = he_bump;
          if (de_bump >= DE_TICKS) begin
            status_nxt  = ST_DOWN;
            changed_nxt = 1'b1;
            reason_nxt  = RSN_DOWN_ENTER;
          end else if (he_bump >= HE_TICKS && dwell_ok) begin
            status_nxt  = ST_HEALTHY;
            changed_nxt = 1'b1;
            reason_nxt  = RSN_HEALTHY_ENTER;
          end
        end
        default: begin
          dx_cnt_nxt = dx_bump;
          if (dx_bump >= DX_TICKS && dwell_ok) begin
            status_nxt  = ST_DEGRADED;
            changed_nxt = 1'b1;
            reason_nxt  = RSN_DOWN_EXIT;
          end
        end
      endcase
    end
    // Any transition restarts every debounce run.
    if (changed_nxt) begin
      hx_cnt_nxt = '0;
      he_cnt_nxt = '0;
      de_cnt_nxt = '0;
      dx_cnt_nxt = '0;
    end
  end

  // State update when the input stage item is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= status_t'(INIT_CODE);
      hx_cnt_r      <= '0;
      he_cnt_r      <= '0;
      de_cnt_r      <= '0;
      dx_cnt_r      <= '0;
      last_change_r <= '0;
      has_changed_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      status_r <= status_nxt;
      hx_cnt_r <= hx_cnt_nxt;
      he_cnt_r <= he_cnt_nxt;
      de_cnt_r <= de_cnt_nxt;
      dx_cnt_r <= dx_cnt_nxt;
      if (changed_nxt) begin
        last_change_r <= s1_time_r;
        has_changed_r <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_status_r  <= status_nxt;
      out_changed_r <= changed_nxt;
      out_reason_r  <= reason_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_reason_r, out_changed_r, out_status_r};

  // The result just loaded reports the status now held in state.
  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> (out_tdata[1:0] == status_r))
    else $error("result status differs from tracked status");

  // A transition clears every counter and records that a change happened.
  a_clear_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && changed_nxt) |=>
      (hx_cnt_r == '0 && he_cnt_r == '0 && de_cnt_r == '0 && dx_cnt_r == '0 &&
       has_changed_r))
    else $error("counters not cleared after transition");

  // The input side stalls only when both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

>>> dv/three_level_health_hysteresis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_health_hysteresis_test
// Self-checking testbench for the three-level health hysteresis block.
// ----------------------------------------------------------------------------
// A scoreboard object tracks status, debounce counters and dwell timing in
// step with the block. For every accepted tick it predicts one status result,
// and it checks each result transaction against the oldest prediction. A
// short directed sequence walks every transition first. Random phases follow,
// each with its own register setting, covering ordered and extreme levels,
// maximum dwell with slowly moving time so counters saturate, and timestamp
// wrap. Both stream sides idle in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module three_level_health_hysteresis_test;
  import tlhh_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int NUM_PHASES = 10;

  // Tracks the expected status and holds the results still to arrive.
  class health_scoreboard;
    logic signed [SCORE_W-1:0] healthy_exit_lvl;
    logic signed [SCORE_W-1:0] healthy_enter_lvl;
    logic signed [SCORE_W-1:0] down_enter_lvl;
    logic signed [SCORE_W-1:0] down_exit_lvl;
    logic [CFG_W-1:0]          dwell_min;
    logic [CONF_W-1:0]         promo_conf;
    logic [CONF_W-1:0]         force_conf;
    logic                      force_en;

    status_t           status;
    logic [CNT_W-1:0]  below_hexit_run;
    logic [CNT_W-1:0]  above_henter_run;
    logic [CNT_W-1:0]  below_denter_run;
    logic [CNT_W-1:0]  above_dexit_run;
    logic [TIME_W-1:0] last_change;
    logic              changed_once;

    logic [7:0] status_q[$];
    int         errors;
    int         checked;

    function new();
      healthy_exit_lvl  = '0;
      healthy_enter_lvl = '0;
      down_enter_lvl    = '0;
      down_exit_lvl     = '0;
      dwell_min         = '0;
      promo_conf        = '0;
      force_conf        = '0;
      force_en          = 1'b0;
      status            = (DEF_INITIAL_STATUS > 2) ? ST_DOWN : status_t'(DEF_INITIAL_STATUS);
      below_hexit_run   = '0;
      above_henter_run  = '0;
      below_denter_run  = '0;
      above_dexit_run   = '0;
      last_change       = '0;
      changed_once      = 1'b0;
      errors            = 0;
      checked           = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_HEALTHY_EXIT_LEVEL:  healthy_exit_lvl  = value;
        CFG_HEALTHY_ENTER_LEVEL: healthy_enter_lvl = value;
        CFG_DOWN_ENTER_LEVEL:    down_enter_lvl    = value;
        CFG_DOWN_EXIT_LEVEL:     down_exit_lvl     = value;
        CFG_MIN_DWELL_TIME:      dwell_min         = value;
        CFG_PROMOTION_CONF:      promo_conf        = value;
        CFG_FORCE_DOWN_CONF:     force_conf        = value;
        CFG_FORCE_DOWN_ENABLE:   force_en          = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function logic [CNT_W-1:0] run_inc(logic [CNT_W-1:0] run);
      return (run == {CNT_W{1'b1}}) ? run : run + 1'b1;
    endfunction

    // Elapsed time wraps modulo 2^32; no dwell before the first transition.
    function bit dwell_ok(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - last_change;
      return (dwell_min == 0) || !changed_once || (elapsed >= TIME_W'(dwell_min));
    endfunction

    function void transition(logic [TIME_W-1:0] now, status_t next, reason_t why);
      status           = next;
      last_change      = now;
      changed_once     = 1'b1;
      below_hexit_run  = '0;
      above_henter_run = '0;
      below_denter_run = '0;
      above_dexit_run  = '0;
      status_q.push_back({2'b00, why, 1'b1, next});
    endfunction

    function void note_tick(logic [TIME_W-1:0] now, logic signed [SCORE_W-1:0] score,
                            logic [CONF_W-1:0] conf);
      bit promo_ok;
      // Low confidence drops straight to down, unless already there.
      if (force_en && conf < force_conf && status != ST_DOWN) begin
        transition(now, ST_DOWN, RSN_FORCED);
        return;
      end
      promo_ok = conf >= promo_conf;
      case (status)
        ST_HEALTHY: begin
          below_hexit_run = (score <= healthy_exit_lvl) ? run_inc(below_hexit_run) : '0;
          if (below_hexit_run >= DEF_HEALTHY_EXIT_TICKS && dwell_ok(now)) begin
            transition(now, ST_DEGRADED, RSN_HEALTHY_EXIT);
            return;
          end
        end
        ST_DEGRADED: begin
          below_denter_run = (score <= down_enter_lvl) ? run_inc(below_denter_run) : '0;
          above_henter_run = (promo_ok && score >= healthy_enter_lvl) ?
                             run_inc(above_henter_run) : '0;
          // Dropping to down does not wait for the dwell time.
          if (below_denter_run >= DEF_DOWN_ENTER_TICKS) begin
            transition(now, ST_DOWN, RSN_DOWN_ENTER);
            return;
          end
          if (above_henter_run >= DEF_HEALTHY_ENTER_TICKS && dwell_ok(now)) begin
            transition(now, ST_HEALTHY, RSN_HEALTHY_ENTER);
            return;
          end
        end
        default: begin
          above_dexit_run = (score >= down_exit_lvl) ? run_inc(above_dexit_run) : '0;
          if (above_dexit_run >= DEF_DOWN_EXIT_TICKS && dwell_ok(now)) begin
            transition(now, ST_DEGRADED, RSN_DOWN_EXIT);
            return;
          end
        end
      endcase
      status_q.push_back({2'b00, RSN_NONE, 1'b0, status});
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at result %0d: %s", checked, msg);
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (status_q.size() == 0) begin
        report($sformatf("result 0x%02h arrived with nothing expected", got));
      end else begin
        want = status_q.pop_front();
        if (got[1:0] !== want[1:0])
          report($sformatf("status_now %0d, expected %0d", got[1:0], want[1:0]));
        if (got[2] !== want[2])
          report($sformatf("changed_flag %0d, expected %0d", got[2], want[2]));
        if (got[5:3] !== want[5:3])
          report($sformatf("reason_code %0d, expected %0d", got[5:3], want[5:3]));
        if (got[7:6] !== 2'b00)
          report($sformatf("padding bits %0d, expected 0", got[7:6]));
      end
      checked++;
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [63:0]      in_tdata;   // [31:0] tick_time, [47:32] score_value, [63:48] confidence_value
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;  // [1:0] status_now, [2] changed_flag, [5:3] reason_code

  health_scoreboard sb;
  logic [CFG_W-1:0] cfg_val [8];
  logic [TIME_W-1:0] tick_clock;
  int  run_left;
  int  run_mode;
  int  idle_cycles;
  bit  calm;
  bit  hold_out;
  bit  slow_time;

  three_level_health_hysteresis i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // End the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_level_health_hysteresis test failed");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready = 1'b0;
        repeat (48) @(negedge clk);
        hold_out   = 1'b0;
        out_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Offer one tick; entered and left at a falling edge.
  task automatic send_tick(logic [TIME_W-1:0] t, logic [SCORE_W-1:0] s,
                           logic [CONF_W-1:0] c);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {c, s, t};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t, s, c);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic apply_regs();
    cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx       = cfg_idx_t'(i);
      cfg_we    = 1'b1;
      cfg_index = idx;
      cfg_wdata = cfg_val[idx];
      sb.write_reg(idx, cfg_val[idx]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  function automatic int level_of(cfg_idx_t idx);
    return int'($signed(cfg_val[idx]));
  endfunction

  // Register setting of one random phase; phases 1 and 2 are extremes.
  function automatic void choose_regs(int phase);
    int de, dx, hx, hn;
    case (phase)
      1: begin
        cfg_val[CFG_HEALTHY_EXIT_LEVEL]  = 16'h8000;
        cfg_val[CFG_HEALTHY_ENTER_LEVEL] = 16'h8000;
        cfg_val[CFG_DOWN_ENTER_LEVEL]    = 16'h8000;
        cfg_val[CFG_DOWN_EXIT_LEVEL]     = 16'h8000;
        cfg_val[CFG_MIN_DWELL_TIME]      = 16'hFFFF;
        cfg_val[CFG_PROMOTION_CONF]      = 16'h0000;
        cfg_val[CFG_FORCE_DOWN_CONF]     = 16'h0001;
        cfg_val[CFG_FORCE_DOWN_ENABLE]   = 16'h0001;
      end
      2: begin
        cfg_val[CFG_HEALTHY_EXIT_LEVEL]  = 16'h7FFF;
        cfg_val[CFG_HEALTHY_ENTER_LEVEL] = 16'h7FFF;
        cfg_val[CFG_DOWN_ENTER_LEVEL]    = 16'h7FFF;
        cfg_val[CFG_DOWN_EXIT_LEVEL]     = 16'h7FFF;
        cfg_val[CFG_MIN_DWELL_TIME]      = 16'hFFFF;
        cfg_val[CFG_PROMOTION_CONF]      = 16'hFFFF;
        cfg_val[CFG_FORCE_DOWN_CONF]     = 16'hFFFF;
        cfg_val[CFG_FORCE_DOWN_ENABLE]   = 16'h0000;
      end
      default: begin
        // Usually ordered levels so that every transition can happen.
        de = -12000 + int'($urandom_range(0, 8000));
        dx = de + int'($urandom_range(0, 3000));
        hx = -2000 + int'($urandom_range(0, 4000));
        hn = hx + int'($urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0) begin
          de = $urandom;
          dx = $urandom;
          hx = $urandom;
          hn = $urandom;
        end
        cfg_val[CFG_HEALTHY_EXIT_LEVEL]  = 16'(hx);
        cfg_val[CFG_HEALTHY_ENTER_LEVEL] = 16'(hn);
        cfg_val[CFG_DOWN_ENTER_LEVEL]    = 16'(de);
        cfg_val[CFG_DOWN_EXIT_LEVEL]     = 16'(dx);
        cfg_val[CFG_MIN_DWELL_TIME]      = 16'($urandom_range(0, 12));
        cfg_val[CFG_PROMOTION_CONF]      = 16'($urandom_range(0, 65535));
        cfg_val[CFG_FORCE_DOWN_CONF]     = 16'($urandom_range(0, 8000));
        cfg_val[CFG_FORCE_DOWN_ENABLE]   = 16'($urandom_range(0, 1));
        if (phase == 0) begin
          cfg_val[CFG_MIN_DWELL_TIME]  = 16'h0000;
          cfg_val[CFG_FORCE_DOWN_CONF] = 16'h0000;
        end
      end
    endcase
  endfunction

  // Scores come in runs of one kind so that the debounce counters fill up.
  function automatic logic [SCORE_W-1:0] pick_score();
    int r, lv;
    if (run_left == 0) begin
      r        = $urandom_range(0, 9);
      run_mode = (r < 4) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
      run_left = $urandom_range(1, 6);
    end
    run_left--;
    case (run_mode)
      0: begin
        lv = level_of(CFG_DOWN_ENTER_LEVEL);
        return 16'(int'($urandom_range(0, lv + 32768)) - 32768);
      end
      1: begin
        lv = level_of(CFG_HEALTHY_ENTER_LEVEL);
        return 16'(lv + int'($urandom_range(0, 32767 - lv)));
      end
      2: return cfg_val[cfg_idx_t'($urandom_range(0, 3))];
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CONF_W-1:0] pick_conf();
    int r;
    logic [CONF_W-1:0] fc;
    r  = $urandom_range(0, 9);
    fc = cfg_val[CFG_FORCE_DOWN_CONF];
    if (r == 0) return (fc == 0) ? '0 : 16'($urandom_range(0, fc - 1));
    if (r == 1) return 16'($urandom);
    return 16'($urandom_range(cfg_val[CFG_PROMOTION_CONF], 65535));
  endfunction

  task automatic send_random_tick();
    logic [SCORE_W-1:0] s;
    logic [CONF_W-1:0]  c;
    if (slow_time) tick_clock += $urandom_range(0, 1);
    else if ($urandom_range(0, 19) == 0) tick_clock = $urandom;
    else tick_clock += $urandom_range(0, 4);
    s = pick_score();
    c = pick_conf();
    send_tick(tick_clock, s, c);
  endtask

  // Main sequence: reset, directed walk, then random phases.
  initial begin
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_HEALTHY_EXIT_LEVEL;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tick_clock  = '0;
    run_left    = 0;
    run_mode    = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_out    = 1'b0;
    slow_time   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed setting: levels -1.0 / +1.0 / -4.0 / -2.0, promotion at 0.5.
    cfg_val[CFG_HEALTHY_EXIT_LEVEL]  = 16'hFF00;
    cfg_val[CFG_HEALTHY_ENTER_LEVEL] = 16'h0100;
    cfg_val[CFG_DOWN_ENTER_LEVEL]    = 16'hFC00;
    cfg_val[CFG_DOWN_EXIT_LEVEL]     = 16'hFE00;
    cfg_val[CFG_MIN_DWELL_TIME]      = 16'h0000;
    cfg_val[CFG_PROMOTION_CONF]      = 16'h8000;
    cfg_val[CFG_FORCE_DOWN_CONF]     = 16'h1000;
    cfg_val[CFG_FORCE_DOWN_ENABLE]   = 16'h0001;
    apply_regs();

    // Healthy exit on the most negative score.
    send_tick(32'd0, 16'h8000, 16'hFFFF);
    send_tick(32'd1, 16'h8000, 16'hFFFF);
    send_tick(32'd2, 16'h8000, 16'hFFFF);
    // Promotion back to healthy on the most positive score.
    send_tick(32'd3, 16'h7FFF, 16'hFFFF);
    send_tick(32'd4, 16'h7FFF, 16'hFFFF);
    send_tick(32'd5, 16'h7FFF, 16'hFFFF);
    // Zero confidence forces down; a second one while down is ignored.
    send_tick(32'd6, 16'h7FFF, 16'h0000);
    send_tick(32'd7, 16'h8000, 16'h0000);
    // Down exit with confidence exactly at the force threshold.
    send_tick(32'd8, 16'h7FFF, 16'h1000);
    send_tick(32'd9, 16'h7FFF, 16'h1000);
    send_tick(32'd10, 16'h7FFF, 16'h1000);
    // Down entry with the score exactly at its level.
    send_tick(32'd11, 16'hFC00, 16'hFFFF);
    send_tick(32'd12, 16'hFC00, 16'hFFFF);
    send_tick(32'd13, 16'hFC00, 16'hFFFF);
    // Down exit with the score exactly at its level.
    send_tick(32'd14, 16'hFE00, 16'h1000);
    send_tick(32'd15, 16'hFE00, 16'h1000);
    send_tick(32'd16, 16'hFE00, 16'h1000);
    // Promotion blocked one step below the confidence threshold, then taken.
    send_tick(32'd17, 16'h0100, 16'h7FFF);
    send_tick(32'd18, 16'h0100, 16'h8000);
    send_tick(32'd19, 16'h0100, 16'h8000);
    send_tick(32'hFFFF_FFFF, 16'h0100, 16'h8000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      choose_regs(p);
      apply_regs();
      // Near-frozen time under maximum dwell lets the counters saturate.
      slow_time = (p == 1 || p == 2);
      if (p == 3) tick_clock = 32'hFFFF_FFF0;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ((p == 1) ? 300 : 50); n++) begin
        if ((p == 4 && n == 20) || (p == 7 && n == 10)) hold_out = 1'b1;
        if (p == 5 && n == 25) wait_drained();
        send_random_tick();
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (sb.errors == 0) begin
      $display("three_level_health_hysteresis test passed");
    end else begin
      $display("three_level_health_hysteresis test failed");
    end
    $finish;
  end

endmodule
